// ----- hw/rtl/cfir_pkg.sv -----
`timescale 1ns / 1ps

package cfir_pkg;

  localparam int TAPS      = 25;
  localparam int TAP_IDX_W = 5;
  localparam int SAMPLE_W  = 16;
  localparam int PROD_W    = 2 * SAMPLE_W;
  localparam int ACC_W     = 38;

  typedef enum logic {
    CMD_FILTER = 1'b0,
    CMD_TAP    = 1'b1
  } cmd_e;

  // one complex 16-bit value: a sample or a coefficient
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] re;
    logic signed [SAMPLE_W-1:0] im;
  } cplx_t;

  // partial sum walking down the cell chain
  typedef struct packed {
    logic                    vld;
    logic signed [ACC_W-1:0] re;
    logic signed [ACC_W-1:0] im;
  } psum_t;

endpackage

// ----- hw/rtl/cfir_cell.sv -----
`timescale 1ns / 1ps

module cfir_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           shift_i,
  input  cfir_pkg::cplx_t sample_i,
  output cfir_pkg::cplx_t sample_o,
  input  logic           tap_we_i,
  input  cfir_pkg::cplx_t tap_i,
  input  cfir_pkg::psum_t psum_i,
  output cfir_pkg::psum_t psum_o
);
  import cfir_pkg::*;

  cplx_t smp_q;
  cplx_t tap_q;

  logic signed [PROD_W-1:0] rr_q, ii_q, ri_q, ir_q;
  logic signed [ACC_W-1:0]  rr_x, ii_x, ri_x, ir_x;

  logic                    vld_q;
  logic signed [ACC_W-1:0] sum_re_q, sum_im_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_q <= '0;
      tap_q <= '0;
      vld_q <= 1'b0;
    end else begin
      if (shift_i) begin
        smp_q <= sample_i;
      end
      if (tap_we_i) begin
        tap_q <= tap_i;
      end
      vld_q <= psum_i.vld;
    end
  end

  // the four partial products, refreshed every cycle
  always_ff @(posedge clk_i) begin
    rr_q <= smp_q.re * tap_q.re;
    ii_q <= smp_q.im * tap_q.im;
    ri_q <= smp_q.re * tap_q.im;
    ir_q <= smp_q.im * tap_q.re;
  end

  assign rr_x = {{(ACC_W-PROD_W){rr_q[PROD_W-1]}}, rr_q};
  assign ii_x = {{(ACC_W-PROD_W){ii_q[PROD_W-1]}}, ii_q};
  assign ri_x = {{(ACC_W-PROD_W){ri_q[PROD_W-1]}}, ri_q};
  assign ir_x = {{(ACC_W-PROD_W){ir_q[PROD_W-1]}}, ir_q};

  // sums wrap at the accumulator width
  always_ff @(posedge clk_i) begin
    if (psum_i.vld) begin
      sum_re_q <= psum_i.re + rr_x - ii_x;
      sum_im_q <= psum_i.im + ri_x + ir_x;
    end
  end

  assign sample_o   = smp_q;
  assign psum_o.vld = vld_q;
  assign psum_o.re  = sum_re_q;
  assign psum_o.im  = sum_im_q;

endmodule

// ----- hw/rtl/complex_fir_filter.sv -----
`timescale 1ns / 1ps

// Complex FIR filter built as a row of TAPS cells (25 here), each holding one delay-line
// sample and one coefficient. A coefficient write (cmd 1) goes straight into its cell; an
// index of TAPS or more is ignored and gives no result. A filter request (cmd 0) shifts the
// sample into the row, then a partial sum walks from cell 0 to the last cell, one cell per
// cycle, and the 38-bit complex result is registered at the output; in_ready_o stays low
// from acceptance until then. The next request is taken once the result has moved into
// the output register, even if it has not been taken yet.
// Delay line and coefficients are cleared by reset.
module complex_fir_filter (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic                                   cmd_i,
  input  logic signed [cfir_pkg::SAMPLE_W-1:0]   sample_real_i,
  input  logic signed [cfir_pkg::SAMPLE_W-1:0]   sample_imag_i,
  input  logic        [cfir_pkg::TAP_IDX_W-1:0]  tap_index_i,
  input  logic signed [cfir_pkg::SAMPLE_W-1:0]   tap_real_i,
  input  logic signed [cfir_pkg::SAMPLE_W-1:0]   tap_imag_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [cfir_pkg::ACC_W-1:0]      out_real_o,
  output logic signed [cfir_pkg::ACC_W-1:0]      out_imag_o
);
  import cfir_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_PROD   = 5'b00010,
    ST_LAUNCH = 5'b00100,
    ST_SUM    = 5'b01000,
    ST_HOLD   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic  accept;
  logic  shift;
  logic  tap_wr;
  logic  out_free;
  logic  load_out;
  cplx_t new_smp;
  cplx_t new_tap;

  cplx_t smp_chain [TAPS+1];
  psum_t sum_chain [TAPS+1];

  logic                    out_vld_q;
  logic signed [ACC_W-1:0] out_re_q, out_im_q;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign shift      = accept && (cmd_e'(cmd_i) == CMD_FILTER);
  assign tap_wr     = accept && (cmd_e'(cmd_i) == CMD_TAP);

  assign new_smp.re = sample_real_i;
  assign new_smp.im = sample_imag_i;
  assign new_tap.re = tap_real_i;
  assign new_tap.im = tap_imag_i;

  assign smp_chain[0]  = new_smp;
  assign sum_chain[0].vld = (state_q == ST_LAUNCH);
  assign sum_chain[0].re  = '0;
  assign sum_chain[0].im  = '0;

  for (genvar g = 0; g < TAPS; g++) begin : g_cell
    cfir_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (shift),
      .sample_i (smp_chain[g]),
      .sample_o (smp_chain[g+1]),
      .tap_we_i (tap_wr && (tap_index_i == TAP_IDX_W'(g))),
      .tap_i    (new_tap),
      .psum_i   (sum_chain[g]),
      .psum_o   (sum_chain[g+1])
    );
  end

  assign out_free = !out_vld_q || out_ready_i;

  always_comb begin
    state_d  = state_q;
    load_out = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (shift) begin
          state_d = ST_PROD;
        end
      end
      ST_PROD:   state_d = ST_LAUNCH;
      ST_LAUNCH: state_d = ST_SUM;
      ST_SUM: begin
        if (sum_chain[TAPS].vld) begin
          if (out_free) begin
            load_out = 1'b1;
            state_d  = ST_IDLE;
          end else begin
            state_d = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // last cell holds its sum until the output register takes it
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_re_q <= sum_chain[TAPS].re;
      out_im_q <= sum_chain[TAPS].im;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_real_o  = out_re_q;
  assign out_imag_o  = out_im_q;

endmodule
